// ===== hdl/bgf_pkg.sv =====
// Package for the background tile pixel fetcher: opcodes, fetch steps,
// configuration register indexes, tile map bases and the tile data address helper.
// No dependencies.
`timescale 1ns / 1ps

package bgf_pkg;

  // Item kinds on the request channel.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_POP   = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  // Steps of the tile fetch sequence.
  typedef enum logic [1:0] {
    STEP_TILE_ID   = 2'd0,
    STEP_DATA_LOW  = 2'd1,
    STEP_DATA_HIGH = 2'd2,
    STEP_WAIT      = 2'd3
  } fetch_step_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SCROLL_X           = 3'd0,
    CFG_SCROLL_Y           = 3'd1,
    CFG_BG_MAP_HIGH        = 3'd2,
    CFG_WINDOW_MAP_HIGH    = 3'd3,
    CFG_TILE_DATA_UNSIGNED = 3'd4
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam int unsigned FIFO_DEPTH_DEF      = 16;
  localparam int unsigned FETCH_THRESHOLD_DEF = 8;
  localparam int unsigned PIXELS_PER_TILE     = 8;

  localparam logic [15:0] MAP_LOW_BASE       = 16'h9800;
  localparam logic [15:0] MAP_HIGH_BASE      = 16'h9C00;
  localparam logic [15:0] DATA_UNSIGNED_BASE = 16'h8000;
  localparam logic [15:0] DATA_SIGNED_BASE   = 16'h9000;

  // Address of the low data byte of a tile row. Unsigned mode indexes up from
  // the low data base; signed mode treats the id as two's complement around
  // the signed base.
  function automatic logic [15:0] tile_data_addr(input logic       unsigned_mode,
                                                 input logic [7:0] id,
                                                 input logic [7:0] line);
    logic [15:0] base;
    if (unsigned_mode) begin
      base = DATA_UNSIGNED_BASE + {4'h0, id, 4'h0};
    end else begin
      base = DATA_SIGNED_BASE + {{4{id[7]}}, id, 4'h0};
    end
    return base + {12'h000, line[2:0], 1'b0};
  endfunction

endpackage

// ===== hdl/bgf_in_if.sv =====
// Request channel of the background tile pixel fetcher.
// Depends on bgf_pkg.
`timescale 1ns / 1ps

interface bgf_in_if
  import bgf_pkg::*;
();
  logic       valid;
  logic       ready;
  opcode_e    opcode;
  logic [7:0] scanline;
  logic       use_window;
  logic [7:0] read_data;

  modport source (output valid, opcode, scanline, use_window, read_data, input ready);
  modport sink   (input valid, opcode, scanline, use_window, read_data, output ready);
endinterface

// ===== hdl/bgf_out_if.sv =====
// Result channel of the background tile pixel fetcher.
// No dependencies.
`timescale 1ns / 1ps

interface bgf_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [1:0]  pixel_color;
  logic [15:0] read_address;
  logic        read_pending;
  logic        fifo_not_empty;

  modport source (output valid, pixel_valid, pixel_color, read_address, read_pending,
                  fifo_not_empty, input ready);
  modport sink   (input valid, pixel_valid, pixel_color, read_address, read_pending,
                  fifo_not_empty, output ready);
endinterface

// ===== hdl/background_tile_pixel_fetcher.sv =====
// Background and window tile pixel fetcher with its pixel FIFO.
// Depends on bgf_pkg, bgf_in_if and bgf_out_if.
`timescale 1ns / 1ps

// Every request produces exactly one result, in the cycle after the request is
// accepted, and while results are taken a new request can be accepted in every
// cycle, one request per clock. The whole update of the fetcher state and the
// pixel FIFO is one short combinational pass from the state registers and the
// request to the next state and the output register. The output register is
// the only buffer between the two sides, so a request is taken whenever that
// register is empty or is being drained in the same cycle; a stalled result
// holds the request side for as long as it waits. A start request latches the
// tile line (scanline plus vertical scroll), the first tile column (upper five
// bits of the horizontal scroll) and the tile map row, and empties the FIFO.
// Every second tick runs one fetch step: tile id read, low data byte read,
// high data byte read, then a wait until the FIFO holds no more than
// FETCH_THRESHOLD pixels and has room for eight, when eight pixels are
// pushed, leftmost first, and the column advances with wrap after 31. The
// byte for the address shown on read_address must be supplied as read_data
// with the acting tick. A pop on an empty FIFO returns pixel_valid low.
// Configuration may only be written while no result is outstanding.
module background_tile_pixel_fetcher
  import bgf_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH      = FIFO_DEPTH_DEF,
  parameter int unsigned FETCH_THRESHOLD = FETCH_THRESHOLD_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  bgf_in_if.sink                 in_i,
  bgf_out_if.source              out_o
);

  localparam int unsigned IdxW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  localparam logic [CntW-1:0] ThreshCnt   = CntW'(FETCH_THRESHOLD);
  localparam logic [CntW-1:0] PushRoomMax = CntW'(FIFO_DEPTH - PIXELS_PER_TILE);
  localparam logic [CntW-1:0] PushCnt     = CntW'(PIXELS_PER_TILE);
  localparam logic [IdxW:0]   DepthWide   = (IdxW + 1)'(FIFO_DEPTH);
  localparam logic [IdxW-1:0] LastIdx     = IdxW'(FIFO_DEPTH - 1);

  // Configuration registers.
  logic [7:0] scroll_x_q, scroll_y_q;
  logic       bg_map_high_q, window_map_high_q, tile_data_unsigned_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q           <= 8'h00;
      scroll_y_q           <= 8'h00;
      bg_map_high_q        <= 1'b0;
      window_map_high_q    <= 1'b0;
      tile_data_unsigned_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCROLL_X:           scroll_x_q           <= cfg_data_i;
        CFG_SCROLL_Y:           scroll_y_q           <= cfg_data_i;
        CFG_BG_MAP_HIGH:        bg_map_high_q        <= cfg_data_i[0];
        CFG_WINDOW_MAP_HIGH:    window_map_high_q    <= cfg_data_i[0];
        CFG_TILE_DATA_UNSIGNED: tile_data_unsigned_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Fetcher state.
  logic [1:0]  tick_phase_q, tick_phase_d;
  fetch_step_e fetch_step_q, fetch_step_d;
  logic [7:0]  tile_line_q, tile_line_d;
  logic [4:0]  tile_column_q, tile_column_d;
  logic [15:0] map_row_base_q, map_row_base_d;
  logic [7:0]  tile_id_q, tile_id_d;
  logic [15:0] data_address_q, data_address_d;
  logic [7:0]  low_byte_q, low_byte_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic [CntW-1:0] queue_count_q, queue_count_d;
  logic [IdxW-1:0] queue_head_q, queue_head_d;

  // Pixel storage. Entries are only read below the fill count, so they need
  // no reset.
  logic [1:0] pixel_queue_q [FIFO_DEPTH];

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        pixel_valid_q, pixel_valid_d;
  logic [1:0]  pixel_color_q, pixel_color_d;
  logic [15:0] read_address_q, read_address_d;
  logic        read_pending_q, read_pending_d;
  logic        fifo_not_empty_q;

  logic in_fire;
  logic push_en;
  logic [IdxW:0]   slot_sum [PIXELS_PER_TILE];
  logic [IdxW-1:0] slot_idx [PIXELS_PER_TILE];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Write slots of the eight pixels of a tile row. A push only happens when
  // head plus count plus offset stays below twice the depth, so one
  // conditional subtract wraps it.
  always_comb begin
    for (int i = 0; i < PIXELS_PER_TILE; i++) begin
      slot_sum[i] = {1'b0, queue_head_q} + (IdxW + 1)'(queue_count_q) + (IdxW + 1)'(i);
      if (slot_sum[i] >= DepthWide) begin
        slot_idx[i] = IdxW'(slot_sum[i] - DepthWide);
      end else begin
        slot_idx[i] = IdxW'(slot_sum[i]);
      end
    end
  end

  always_comb begin
    tick_phase_d   = tick_phase_q;
    fetch_step_d   = fetch_step_q;
    tile_line_d    = tile_line_q;
    tile_column_d  = tile_column_q;
    map_row_base_d = map_row_base_q;
    tile_id_d      = tile_id_q;
    data_address_d = data_address_q;
    low_byte_d     = low_byte_q;
    high_byte_d    = high_byte_q;
    queue_count_d  = queue_count_q;
    queue_head_d   = queue_head_q;
    push_en        = 1'b0;
    pixel_valid_d  = 1'b0;
    pixel_color_d  = 2'b00;

    if (in_fire) begin
      unique case (in_i.opcode)
        OP_START: begin
          tick_phase_d   = 2'd0;
          tile_line_d    = in_i.scanline + scroll_y_q;
          tile_column_d  = scroll_x_q[7:3];
          map_row_base_d = ((in_i.use_window ? window_map_high_q : bg_map_high_q)
                            ? MAP_HIGH_BASE : MAP_LOW_BASE)
                           + {6'b000000, tile_line_d[7:3], 5'b00000};
          queue_count_d  = '0;
          queue_head_d   = '0;
          fetch_step_d   = STEP_TILE_ID;
        end
        OP_TICK: begin
          tick_phase_d = tick_phase_q + 2'd1;
          // Odd phases are the acting ticks.
          if (tick_phase_q[0]) begin
            unique case (fetch_step_q)
              STEP_TILE_ID: begin
                tile_id_d    = in_i.read_data;
                fetch_step_d = STEP_DATA_LOW;
              end
              STEP_DATA_LOW: begin
                data_address_d = tile_data_addr(tile_data_unsigned_q, tile_id_q,
                                                tile_line_q);
                low_byte_d     = in_i.read_data;
                fetch_step_d   = STEP_DATA_HIGH;
              end
              STEP_DATA_HIGH: begin
                high_byte_d  = in_i.read_data;
                fetch_step_d = STEP_WAIT;
              end
              STEP_WAIT: begin
                if (queue_count_q <= ThreshCnt && queue_count_q <= PushRoomMax) begin
                  push_en       = 1'b1;
                  queue_count_d = queue_count_q + PushCnt;
                  tile_column_d = tile_column_q + 5'd1;
                  fetch_step_d  = STEP_TILE_ID;
                end
              end
            endcase
          end
        end
        OP_POP: begin
          if (queue_count_q != '0) begin
            pixel_valid_d = 1'b1;
            pixel_color_d = pixel_queue_q[queue_head_q];
            queue_head_d  = (queue_head_q == LastIdx) ? '0 : queue_head_q + IdxW'(1);
            queue_count_d = queue_count_q - CntW'(1);
          end
        end
        OP_NOP: ;
      endcase
    end
  end

  // Read address announced for the next acting tick, from the updated state.
  always_comb begin
    unique case (fetch_step_d)
      STEP_TILE_ID: begin
        read_address_d = map_row_base_d + {11'h000, tile_column_d};
        read_pending_d = 1'b1;
      end
      STEP_DATA_LOW: begin
        read_address_d = tile_data_addr(tile_data_unsigned_q, tile_id_d, tile_line_d);
        read_pending_d = 1'b1;
      end
      STEP_DATA_HIGH: begin
        read_address_d = data_address_d + 16'h0001;
        read_pending_d = 1'b1;
      end
      STEP_WAIT: begin
        read_address_d = 16'h0000;
        read_pending_d = 1'b0;
      end
    endcase
  end

  assign out_valid_d = in_fire || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_phase_q   <= 2'd0;
      fetch_step_q   <= STEP_TILE_ID;
      tile_line_q    <= 8'h00;
      tile_column_q  <= 5'd0;
      map_row_base_q <= 16'h0000;
      tile_id_q      <= 8'h00;
      data_address_q <= 16'h0000;
      low_byte_q     <= 8'h00;
      high_byte_q    <= 8'h00;
      queue_count_q  <= '0;
      queue_head_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      tick_phase_q   <= tick_phase_d;
      fetch_step_q   <= fetch_step_d;
      tile_line_q    <= tile_line_d;
      tile_column_q  <= tile_column_d;
      map_row_base_q <= map_row_base_d;
      tile_id_q      <= tile_id_d;
      data_address_q <= data_address_d;
      low_byte_q     <= low_byte_d;
      high_byte_q    <= high_byte_d;
      queue_count_q  <= queue_count_d;
      queue_head_q   <= queue_head_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Result payload, loaded only when a request is taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pixel_valid_q    <= pixel_valid_d;
      pixel_color_q    <= pixel_color_d;
      read_address_q   <= read_address_d;
      read_pending_q   <= read_pending_d;
      fifo_not_empty_q <= (queue_count_d != '0);
    end
  end

  // Pixel FIFO writes: bit 7 of the data bytes is the leftmost pixel.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      for (int i = 0; i < PIXELS_PER_TILE; i++) begin
        pixel_queue_q[slot_idx[i]] <= {high_byte_q[7 - i], low_byte_q[7 - i]};
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pixel_valid    = pixel_valid_q;
  assign out_o.pixel_color    = pixel_color_q;
  assign out_o.read_address   = read_address_q;
  assign out_o.read_pending   = read_pending_q;
  assign out_o.fifo_not_empty = fifo_not_empty_q;

endmodule

// ===== hdl/bgf_checker.sv =====
// Port-level checks for the background tile pixel fetcher, bound to its top level.
// Depends on the top level's channel interfaces through the bind connections.
`timescale 1ns / 1ps

module bgf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        pixel_valid_i,
  input logic [1:0]  pixel_color_i,
  input logic [15:0] read_address_i,
  input logic        read_pending_i
);

  // Every accepted request shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted request produced no result");

  // The request side is never held while the result register is empty.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request stalled with empty result register");

  // A result without a pixel carries color zero.
  a_no_pixel_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pixel_valid_i |-> pixel_color_i == 2'b00)
    else $error("color set without a popped pixel");

  // In the wait step no memory read is announced.
  a_wait_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !read_pending_i |-> read_address_i == 16'h0000)
    else $error("address shown while no read is pending");

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind background_tile_pixel_fetcher bgf_checker u_bgf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .pixel_valid_i  (out_o.pixel_valid),
  .pixel_color_i  (out_o.pixel_color),
  .read_address_i (out_o.read_address),
  .read_pending_i (out_o.read_pending)
);

// ===== dv/tb_background_tile_pixel_fetcher.sv =====
// Self-checking testbench for the background tile pixel fetcher: start, tick and pop
// requests with random handshake gaps, checked against a cycle-free predictor.
// Depends on bgf_pkg, bgf_in_if, bgf_out_if and background_tile_pixel_fetcher.
`timescale 1ns / 1ps

module tb_background_tile_pixel_fetcher;
  import bgf_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 250;

  // One request as the sender offers it.
  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] scanline;
    logic       use_window;
    logic [7:0] read_data;
  } fetch_request_t;

  // One result as the block returns it.
  typedef struct packed {
    logic        pixel_valid;
    logic [1:0]  pixel_color;
    logic [15:0] read_address;
    logic        read_pending;
    logic        fifo_not_empty;
  } fetch_result_t;

  // The scoreboard keeps its own copy of the registers and of the fetcher state.
  // Every accepted request advances that copy and queues the result it must cause;
  // every accepted result is compared with the oldest queued one.
  class pixel_fetch_scoreboard;
    logic [7:0]    scroll_x, scroll_y;
    logic          bg_map_high, window_map_high, tile_data_unsigned;
    logic [1:0]    tick_phase;
    fetch_step_e   fetch_step;
    logic [7:0]    tile_line, tile_id, low_byte, high_byte;
    logic [4:0]    tile_column;
    logic [15:0]   map_row_base, data_address;
    logic [1:0]    pixel_fifo[$];
    fetch_result_t expected_results[$];
    int unsigned   errors, lines_started, tiles_pushed, pixels_popped, empty_pops;

    function new();
      scroll_x = '0; scroll_y = '0; bg_map_high = 1'b0; window_map_high = 1'b0;
      tile_data_unsigned = 1'b1;
      tick_phase = '0; fetch_step = STEP_TILE_ID; tile_line = '0; tile_column = '0;
      map_row_base = '0; tile_id = '0; data_address = '0; low_byte = '0; high_byte = '0;
      errors = 0; lines_started = 0; tiles_pushed = 0; pixels_popped = 0; empty_pops = 0;
    endfunction

    function void write_reg(cfg_reg_e index, logic [7:0] value);
      case (index)
        CFG_SCROLL_X:           scroll_x = value;
        CFG_SCROLL_Y:           scroll_y = value;
        CFG_BG_MAP_HIGH:        bg_map_high = value[0];
        CFG_WINDOW_MAP_HIGH:    window_map_high = value[0];
        CFG_TILE_DATA_UNSIGNED: tile_data_unsigned = value[0];
        default: ;
      endcase
    endfunction

    // Low data byte of the current tile row. In signed mode ids from 0x80 up
    // land one 4 KiB block below the signed base.
    function logic [15:0] low_byte_address();
      logic [15:0] base;
      if (tile_data_unsigned) begin
        base = DATA_UNSIGNED_BASE + {4'h0, tile_id, 4'h0};
      end else begin
        base = DATA_SIGNED_BASE + {4'h0, tile_id, 4'h0};
        if (tile_id[7]) base = base - 16'h1000;
      end
      return base + {12'h000, tile_line[2:0], 1'b0};
    endfunction

    function void run_fetch_step(logic [7:0] data);
      case (fetch_step)
        STEP_TILE_ID: begin
          tile_id = data;
          fetch_step = STEP_DATA_LOW;
        end
        STEP_DATA_LOW: begin
          data_address = low_byte_address();
          low_byte = data;
          fetch_step = STEP_DATA_HIGH;
        end
        STEP_DATA_HIGH: begin
          high_byte = data;
          fetch_step = STEP_WAIT;
        end
        default: begin
          if (pixel_fifo.size() <= FETCH_THRESHOLD_DEF &&
              pixel_fifo.size() + PIXELS_PER_TILE <= FIFO_DEPTH_DEF) begin
            for (int i = 7; i >= 0; i--) pixel_fifo.push_back({high_byte[i], low_byte[i]});
            tile_column = tile_column + 5'd1;
            fetch_step = STEP_TILE_ID;
            tiles_pushed++;
          end
        end
      endcase
    endfunction

    function void note_request(fetch_request_t req);
      fetch_result_t res;
      logic          map_sel;
      res = '0;
      case (req.opcode)
        OP_START: begin
          map_sel = req.use_window ? window_map_high : bg_map_high;
          tick_phase = '0;
          tile_line = req.scanline + scroll_y;
          tile_column = scroll_x[7:3];
          map_row_base = (map_sel ? MAP_HIGH_BASE : MAP_LOW_BASE) +
                         {6'h00, tile_line[7:3], 5'h00};
          pixel_fifo.delete();
          fetch_step = STEP_TILE_ID;
          lines_started++;
        end
        OP_TICK: begin
          // Only odd phases act; the phase counter wraps at four either way.
          if (tick_phase[0]) run_fetch_step(req.read_data);
          tick_phase = tick_phase + 2'd1;
        end
        OP_POP: begin
          if (pixel_fifo.size() != 0) begin
            res.pixel_valid = 1'b1;
            res.pixel_color = pixel_fifo.pop_front();
            pixels_popped++;
          end else begin
            empty_pops++;
          end
        end
        default: ;
      endcase
      case (fetch_step)
        STEP_TILE_ID: begin
          res.read_address = map_row_base + {11'h000, tile_column};
          res.read_pending = 1'b1;
        end
        STEP_DATA_LOW: begin
          res.read_address = low_byte_address();
          res.read_pending = 1'b1;
        end
        STEP_DATA_HIGH: begin
          res.read_address = data_address + 16'd1;
          res.read_pending = 1'b1;
        end
        default: ;
      endcase
      res.fifo_not_empty = (pixel_fifo.size() != 0);
      expected_results.push_back(res);
    endfunction

    function void report_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(fetch_result_t got);
      fetch_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      report_field("pixel_valid", want.pixel_valid, got.pixel_valid);
      report_field("pixel_color", want.pixel_color, got.pixel_color);
      report_field("read_address", want.read_address, got.read_address);
      report_field("read_pending", want.read_pending, got.read_pending);
      report_field("fifo_not_empty", want.fifo_not_empty, got.fifo_not_empty);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  bgf_in_if  in_ch ();
  bgf_out_if out_ch ();

  pixel_fetch_scoreboard scoreboard = new();

  // Shared between the request side and the result side. quiet_mode turns all
  // random idling off; hold_off_request asks the result side for one long stall.
  bit          quiet_mode;
  bit          hold_off_request;
  int unsigned requests_sent;
  int unsigned settings_used;

  background_tile_pixel_fetcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A gap length: mostly short, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic fetch_request_t make_request(opcode_e op, logic [7:0] line, logic win,
                                                  logic [7:0] data);
    fetch_request_t req;
    req.opcode = op;
    req.scanline = line;
    req.use_window = win;
    req.read_data = data;
    return req;
  endfunction

  // Mostly ticks and pops, so that fetches run through all their steps and the
  // FIFO both fills up and drains. Starts and no-ops are sprinkled in.
  function automatic fetch_request_t random_request(int unsigned pop_pct);
    fetch_request_t req;
    int unsigned    r;
    r = $urandom_range(0, 99);
    req.scanline = 8'($urandom_range(0, 255));
    req.use_window = 1'($urandom_range(0, 1));
    req.read_data = 8'($urandom_range(0, 255));
    if (r < 4) req.opcode = OP_START;
    else if (r < 7) req.opcode = OP_NOP;
    else if (r < 7 + pop_pct) req.opcode = OP_POP;
    else req.opcode = OP_TICK;
    return req;
  endfunction

  // Offers one request and returns in the time step in which it was accepted.
  // Valid stays high so that a following request needs no second assignment.
  task automatic send_request(fetch_request_t req);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= req.opcode;
    in_ch.scanline   <= req.scanline;
    in_ch.use_window <= req.use_window;
    in_ch.read_data  <= req.read_data;
    do @(posedge clk_i); while (!in_ch.ready);
    scoreboard.note_request(req);
    requests_sent++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = (quiet_mode || $urandom_range(0, 99) < 55) ? 0 : idle_gap();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected result has come back. The
  // block answers every request, so an empty queue means it is idle.
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (scoreboard.expected_results.size() != 0);
  endtask

  // Leaves the write enable high so that back-to-back writes need no toggle.
  task automatic write_register(cfg_reg_e index, logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    scoreboard.write_reg(index, value);
  endtask

  task automatic configure(logic [7:0] sx, logic [7:0] sy, logic bg, logic win, logic uns);
    write_register(CFG_SCROLL_X, sx);
    write_register(CFG_SCROLL_Y, sy);
    write_register(CFG_BG_MAP_HIGH, {7'h00, bg});
    write_register(CFG_WINDOW_MAP_HIGH, {7'h00, win});
    write_register(CFG_TILE_DATA_UNSIGNED, {7'h00, uns});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Result side: checks every accepted result, then decides ready for the next
  // cycle. Random stalls of mixed length, none in quiet phases, and one long
  // hold-off counted here while the request side keeps offering.
  initial begin : result_side
    int unsigned   stall;
    fetch_result_t got;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.pixel_valid    = out_ch.pixel_valid;
        got.pixel_color    = out_ch.pixel_color;
        got.read_address   = out_ch.read_address;
        got.read_pending   = out_ch.read_pending;
        got.fifo_not_empty = out_ch.fifo_not_empty;
        scoreboard.check_result(got);
      end
      if (hold_off_request) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end else if (stall == 0 && !quiet_mode && $urandom_range(0, 3) == 0) begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Request side: reset, a directed opening, then random phases each under a
  // new register setting written while the block is idle.
  initial begin : request_side
    fetch_request_t directed[$];
    int unsigned    pop_pct;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NOP;
    in_ch.scanline = '0;
    in_ch.use_window = 1'b0;
    in_ch.read_data = '0;
    quiet_mode = 1'b0;
    hold_off_request = 1'b0;
    requests_sent = 0;
    settings_used = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both scrolls at their maximum so the tile line wraps past 255 and the
    // first column is 31, which wraps to 0 after the push. Signed tile data.
    configure(8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
    directed.push_back(make_request(OP_POP, 8'h00, 1'b0, 8'h00));    // pop on empty FIFO
    directed.push_back(make_request(OP_NOP, 8'hFF, 1'b1, 8'hFF));
    directed.push_back(make_request(OP_START, 8'hFF, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'hAA));   // idle tick, data unused
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h80));   // most negative tile id
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'hFF));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h5A));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));   // push, column wraps
    directed.push_back(make_request(OP_POP, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_POP, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_START, 8'h00, 1'b1, 8'h00));  // window map
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h7F));   // most positive tile id
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'hFF));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_TICK, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_POP, 8'h00, 1'b0, 8'h00));
    directed.push_back(make_request(OP_NOP, 8'h00, 1'b0, 8'h00));
    foreach (directed[i]) begin
      send_request(directed[i]);
      sender_gap();
    end
    wait_all_results();

    // Phases do not begin with a start, so a setting often changes while a
    // fetch is half done. The first two phases use the register extremes.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) configure(8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
      else if (phase == 1) configure(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
      else configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      quiet_mode = (phase % 3 == 2);
      pop_pct = $urandom_range(20, 50);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // A long stall on the result side fills the output register and
        // blocks further requests while they keep being offered.
        if (phase == 3 && k == 60) hold_off_request = 1'b1;
        // Once, the request side pauses mid-phase until the block is empty.
        if (phase == 5 && k == 100) wait_all_results();
        send_request(random_request(pop_pct));
        sender_gap();
      end
      wait_all_results();
    end
    quiet_mode = 1'b1;
    repeat (5) @(posedge clk_i);

    if (scoreboard.expected_results.size() != 0) begin
      scoreboard.errors++;
      $display("%0t: %0d results never arrived", $time, scoreboard.expected_results.size());
    end
    $display("Sent %0d requests under %0d register settings: %0d lines started, %0d tiles",
             requests_sent, settings_used, scoreboard.lines_started, scoreboard.tiles_pushed);
    $display("fetched, %0d pixels popped, %0d pops on an empty FIFO.",
             scoreboard.pixels_popped, scoreboard.empty_pops);
    if (scoreboard.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : run_limit
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
